/* src/mps_pkg.sv */
// Shared types and constants for the mono page sprite blitter.
// Used by mps_addr and the top module; depends on nothing else.
package mps_pkg;

   // Operation codes carried in the opcode field.
   localparam logic [1:0] OP_PUT    = 2'd0;
   localparam logic [1:0] OP_SPRITE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // Register reset value and pixel geometry.
   localparam logic [7:0] ROW_BYTES_RESET = 8'd50;
   localparam logic [7:0] MSB_MASK        = 8'h80;
   localparam int unsigned ROWS_PER_PAGE  = 8;

   // Row base (y * row_bytes) fits 16 bits; a full byte address with the
   // column byte added is compared against the store size in 17 bits.
   localparam int unsigned BASE_W = 16;
   localparam int unsigned FULL_W = 17;

   // One input beat.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  origin_x;
      logic [7:0]  origin_y;
      logic        color;
      logic [7:0]  column;
      logic [4:0]  page;
      logic [7:0]  pixels;
      logic [7:0]  sprite_width;
      logic [7:0]  sprite_height;
      logic [13:0] read_address;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] read_data;
      logic       dropped;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW,
      ST_WRITE,
      ST_RDATA,
      ST_DONE
   } state_type;

   // Control from the sequencer to the address unit.
   typedef struct packed {
      logic load;
      logic advance;
   } addr_ctl_type;

   // Bit mask of pixel x within its store byte, MSB first.
   function automatic logic [7:0] pixel_mask(input logic [2:0] bit_sel);
      pixel_mask = MSB_MASK >> bit_sel;
   endfunction

endpackage

/* src/mps_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; holds no reset state.
module mps_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16384,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One access per cycle: a write, or a read whose data shows next cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/mps_addr.sv */
// Byte address generator for pixel writes: keeps the current row base.
// Uses mps_pkg for widths and the control struct.
module mps_addr import mps_pkg::*; #(
   parameter int unsigned STORE_BYTES = 16384,
   localparam int unsigned ADDR_W     = $clog2(STORE_BYTES)
) (
   input  logic              clock,
   input  addr_ctl_type      ctl,
   input  logic [7:0]        load_y,
   input  logic [4:0]        load_xbyte,
   input  logic [7:0]        row_bytes,
   output logic [ADDR_W-1:0] addr,
   output logic              in_range
);

   logic [7:0]        y_ff;
   logic [BASE_W-1:0] base_ff;
   logic [4:0]        xbyte_ff;
   logic [FULL_W-1:0] full_addr;

   // Load multiplies the start row once; each step moves one row down,
   // wrapping from row 255 back to row 0.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         y_ff     <= load_y;
         base_ff  <= {8'd0, load_y} * {8'd0, row_bytes};
         xbyte_ff <= load_xbyte;
      end else if (ctl.advance) begin
         y_ff <= y_ff + 8'd1;
         if (y_ff == 8'hFF) begin
            base_ff <= '0;
         end else begin
            base_ff <= base_ff + {8'd0, row_bytes};
         end
      end
   end

   // Byte address and range check against the store size.
   assign full_addr = {1'b0, base_ff} + {12'd0, xbyte_ff};
   assign in_range  = full_addr < FULL_W'(STORE_BYTES);
   assign addr      = full_addr[ADDR_W-1:0];

endmodule

/* src/mono_page_sprite_blitter.sv */
// Mono page sprite blitter: 1 bpp frame store with pixel, sprite and read ops.
// Depends on mps_pkg, mps_addr and mps_ram.
//
// Usage:
//   req channel (req_valid / req_stall / req_data) takes one operation a beat.
//   rsp channel (rsp_valid / rsp_stall / rsp_data) returns one result beat
//   for every operation, in order. csr channel (csr_valid / csr_ready /
//   csr_data) writes row_bytes and is always ready; the user must write it
//   only while no operation is in flight, which the block does not enforce.
// Sequence: a read registers the addressed byte before the done state; an
//   unused opcode, or a sprite byte whose column is not below sprite_width,
//   goes straight to done. A put pixel or sprite byte walks its rows; a
//   sprite row with a set bit in range costs a read and a write of the
//   single-port store. One operation is in flight at a time; the next is
//   accepted the cycle after its result is loaded into the output register.
// Reset: the store is cleared by a pass over all STORE_BYTES bytes, one byte
//   a cycle; req_stall is high for its length. row_bytes resets to 50.
// Stall: a result waits in the output register while rsp_stall is high; one
//   more operation may be taken meanwhile and holds when it finishes.
module mono_page_sprite_blitter import mps_pkg::*; #(
   parameter int unsigned STORE_BYTES = 16384
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

   state_type         state_ff, state_in;
   logic [7:0]        row_bytes_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [2:0]        k_ff;
   logic [7:0]        row_ff;
   logic [7:0]        sh_ff;
   logic [7:0]        pixels_ff;
   logic [7:0]        mask_ff;
   logic              set_ff;
   logic              dropped_ff;
   logic [7:0]        data_ff;
   logic              rd_hit_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_accept;
   logic [7:0]        pix_x, pix_y;
   logic [FULL_W-1:0] rd_full;
   logic              rd_in_range;
   logic              ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_in_range;
   addr_ctl_type      addr_ctl;
   logic              step, drop_set, rsp_load;

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= ROW_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         row_bytes_ff <= csr_data;
      end
   end

   // Input decode: target pixel and read address range.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_data.opcode == OP_SPRITE) begin
         pix_x = req_data.origin_x + req_data.column;
         pix_y = req_data.origin_y + {req_data.page, 3'd0};
      end else begin
         pix_x = req_data.origin_x;
         pix_y = req_data.origin_y;
      end
   end

   assign rd_full     = {3'd0, req_data.read_address};
   assign rd_in_range = rd_full < FULL_W'(STORE_BYTES);

   assign addr_ctl.load    = req_accept;
   assign addr_ctl.advance = step;

   mps_addr #(
      .STORE_BYTES(STORE_BYTES)
   ) u_addr (
      .clock     (clock),
      .ctl       (addr_ctl),
      .load_y    (pix_y),
      .load_xbyte(pix_x[7:3]),
      .row_bytes (row_bytes_ff),
      .addr      (wr_addr),
      .in_range  (wr_in_range)
   );

   mps_ram #(
      .WIDTH(8),
      .DEPTH(STORE_BYTES)
   ) u_store (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, store access and datapath strobes.
   always_comb begin
      state_in  = state_ff;
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = wr_addr;
      ram_wdata = '0;
      step      = 1'b0;
      drop_set  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = clr_cnt_ff;
            if (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.opcode)
                  OP_PUT: state_in = ST_ROW;
                  OP_SPRITE: begin
                     if (req_data.column < req_data.sprite_width) begin
                        state_in = ST_ROW;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  OP_READ: begin
                     ram_en   = rd_in_range;
                     ram_addr = rd_full[ADDR_W-1:0];
                     state_in = ST_RDATA;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ROW: begin
            if (row_ff >= sh_ff) begin
               state_in = ST_DONE;
            end else if (pixels_ff[0] && wr_in_range) begin
               ram_en   = 1'b1;
               state_in = ST_WRITE;
            end else begin
               drop_set = pixels_ff[0];
               step     = 1'b1;
               if (k_ff == 3'(ROWS_PER_PAGE - 1)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_WRITE: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = set_ff ? (ram_rdata | mask_ff) : (ram_rdata & ~mask_ff);
            step      = 1'b1;
            if (k_ff == 3'(ROWS_PER_PAGE - 1)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_RDATA: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (state_ff == ST_CLEAR) begin
         clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
      end
   end

   // Operation registers: row walk, source bits, mask and result fields.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         k_ff       <= '0;
         mask_ff    <= pixel_mask(pix_x[2:0]);
         dropped_ff <= 1'b0;
         data_ff    <= '0;
         rd_hit_ff  <= rd_in_range;
         if (req_data.opcode == OP_SPRITE) begin
            row_ff    <= {req_data.page, 3'd0};
            sh_ff     <= req_data.sprite_height;
            pixels_ff <= req_data.pixels;
            set_ff    <= 1'b1;
         end else begin
            row_ff    <= 8'd0;
            sh_ff     <= 8'd1;
            pixels_ff <= 8'd1;
            set_ff    <= req_data.color;
         end
      end else begin
         if (step) begin
            k_ff      <= k_ff + 3'd1;
            row_ff    <= row_ff + 8'd1;
            pixels_ff <= pixels_ff >> 1;
         end
         if (drop_set) begin
            dropped_ff <= 1'b1;
         end
         if (state_ff == ST_RDATA) begin
            data_ff <= rd_hit_ff ? ram_rdata : 8'd0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.read_data <= data_ff;
         rsp_data_ff.dropped   <= dropped_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // No operation may enter while the store is being cleared.
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("operation accepted during clearing pass");

   // Store writes come only from the clearing pass or a modify step.
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      (ram_en && ram_we) |-> (state_ff == ST_CLEAR || state_ff == ST_WRITE))
      else $error("store write outside clear or modify");

   // A modify step always follows the read of the same byte.
   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> $past(ram_en && !ram_we))
      else $error("modify without a preceding read");

   // A pending result is never overwritten while the receiver stalls.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("result register overwritten under stall");
`endif

endmodule
